[design/lwma_pkg.sv]
// Shared types and constants for the limited weighted moving average block.
// No dependencies; every design file refers to this package by scoped names.

package lwma_pkg;

   // Default geometry
   localparam int WINDOW_DEF      = 20;
   localparam int SAMPLE_BITS_DEF = 20;

   // Register file layout
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;
   localparam int MIN_VALID_BITS = 20;
   localparam int BLEND_BITS     = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE         = 2'd0,
      CSR_MIN_VALID    = 2'd1,
      CSR_BLEND_WEIGHT = 2'd2
   } csr_index_type;

   localparam logic                             MODE_PLAIN      = 1'b0;
   localparam logic                             MODE_RESET      = 1'b1;
   localparam logic signed [MIN_VALID_BITS-1:0] MIN_VALID_RESET = -20'sd256000;
   localparam logic        [BLEND_BITS-1:0]     BLEND_RESET     = 5'd10;

   // Sample classification codes
   localparam int CLASS_BITS = 2;
   typedef enum logic [CLASS_BITS-1:0] {
      CLASS_STORED   = 2'd0,
      CLASS_BLENDED  = 2'd1,
      CLASS_REPLACED = 2'd2,
      CLASS_REJECTED = 2'd3
   } sample_class_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_BLEND_MUL,
      ST_BLEND_START,
      ST_BLEND_WAIT,
      ST_STORE,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_FINISH
   } lwma_state_type;

endpackage

[design/lwma_cell.sv]
// One cell of the sample window shift chain.
// Depends on lwma_pkg for the default width; instantiated in a row by the top level.

module lwma_cell #(
   parameter int WIDTH = lwma_pkg::SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic signed [WIDTH-1:0] d,
   output logic signed [WIDTH-1:0] q
);

   logic signed [WIDTH-1:0] value_ff;
   logic signed [WIDTH-1:0] value_in;

   // Take the neighbor's value on a shift, hold otherwise.
   assign value_in = shift_en ? d : value_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign q = value_ff;

endmodule

[design/lwma_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Positive divisor only. Uses lwma_pkg for defaults.

module lwma_div #(
   parameter int ACC_BITS = lwma_pkg::SAMPLE_BITS_DEF + 5,
   parameter int DEN_BITS = 5,
   parameter int Q_BITS   = lwma_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [ACC_BITS-1:0] dividend,
   input  logic        [DEN_BITS-1:0] divisor,
   output logic                       done,
   output logic signed [Q_BITS-1:0]   quotient
);

   localparam int STEP_BITS = (ACC_BITS > 1) ? $clog2(ACC_BITS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [DEN_BITS-1:0]   rem_ff, rem_in;
   logic [ACC_BITS-1:0]   quo_ff, quo_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;
   logic                  neg_ff, neg_in;

   logic [DEN_BITS:0]     rem_shift;
   logic [DEN_BITS:0]     rem_diff;
   logic [ACC_BITS-1:0]   dividend_mag;
   logic [ACC_BITS-1:0]   quo_signed;

   assign dividend_mag = dividend[ACC_BITS-1] ? (-dividend) : dividend;
   assign rem_shift    = {rem_ff, quo_ff[ACC_BITS-1]};
   assign rem_diff     = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(ACC_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend_mag;
         den_in  = divisor;
         neg_in  = dividend[ACC_BITS-1];
      end else if (busy_ff) begin
         // Shift in the next dividend bit, subtract when it fits.
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[DEN_BITS-1:0];
            quo_in = {quo_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_BITS-1:0];
            quo_in = {quo_ff[ACC_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quo_signed = neg_ff ? (-quo_ff) : quo_ff;
   assign quotient   = quo_signed[Q_BITS-1:0];
   assign done       = done_ff;

endmodule

[design/limited_weighted_moving_average.sv]
// Top level of the limited weighted moving average filter.
// Depends on lwma_pkg, lwma_cell (window shift chain) and lwma_div (serial divider).
//
//  channel | ports                           | beat contents
//  --------+---------------------------------+-----------------------------------------
//  input   | req_tvalid req_tready req_tdata | tdata: sample
//  result  | rsp_tvalid rsp_tready rsp_tdata | tdata: mean; tuser: sample_class, full
//          | rsp_tuser                       |
//  config  | csr_we csr_index csr_wdata      | 0 mode, 1 min_valid, 2 blend_weight
//
// One item at a time. A stored sample passes the classify, store, mean start, mean
// wait and finish states; a blended sample also passes the blend multiply, start and
// wait states; a rejected one goes from classify to finish. The serial divider forms
// the mean, one quotient bit per cycle; the blend divides by the window length with
// a reciprocal multiply. Reset is synchronous and clears fill count, sum, mean and
// the sequencer; window cells are not cleared, since only filled cells are ever
// read. A result waits in the output register while the next beat is accepted; a
// stalled result holds the sequencer only where the next result is ready.

module limited_weighted_moving_average #(
   parameter int WINDOW      = lwma_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = lwma_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,   // [SAMPLE_BITS-1:0] sample
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,   // [SAMPLE_BITS-1:0] mean
   output logic [lwma_pkg::CLASS_BITS:0]        rsp_tuser,   // [1:0] sample_class, [2] full
   // configuration
   input  logic                                 csr_we,
   input  logic [lwma_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lwma_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CNT_BITS  = $clog2(WINDOW + 1);
   localparam int ACC_BITS  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int MAG_BITS  = SAMPLE_BITS + 3;
   localparam int LIM_BITS  = ((SAMPLE_BITS > lwma_pkg::MIN_VALID_BITS) ?
                               SAMPLE_BITS : lwma_pkg::MIN_VALID_BITS) + 1;
   localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int MB        = lwma_pkg::MIN_VALID_BITS;
   // Reciprocal of the window length, rounded up; exact for any blend sum magnitude.
   localparam int BLEND_SHIFT = ACC_BITS + $clog2(WINDOW);
   localparam logic [ACC_BITS:0] BLEND_RECIP =
      (ACC_BITS+1)'(((64'd1 << BLEND_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   // configuration registers
   logic                                mode_ff, mode_in;
   logic signed [MB-1:0]                min_valid_ff, min_valid_in;
   logic [lwma_pkg::BLEND_BITS-1:0]     blend_ff, blend_in;

   // sequencer and filter state
   lwma_pkg::lwma_state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]                 fill_ff, fill_in;
   logic signed [ACC_BITS-1:0]          sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0]       mean_ff, mean_in;

   // per-item working registers
   logic signed [SAMPLE_BITS-1:0]       sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0]       value_ff, value_in;
   lwma_pkg::sample_class_type          class_ff, class_in;
   logic signed [ACC_BITS-1:0]          prod_a_ff, prod_a_in;
   logic signed [ACC_BITS-1:0]          prod_b_ff, prod_b_in;
   logic                                blend_neg_ff, blend_neg_in;
   logic [ACC_BITS-1:0]                 blend_mag_ff, blend_mag_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]       rsp_mean_ff, rsp_mean_in;
   lwma_pkg::sample_class_type          rsp_class_ff, rsp_class_in;
   logic                                rsp_full_ff, rsp_full_in;

   // window chain
   logic signed [SAMPLE_BITS-1:0]       cell_q [WINDOW];
   logic                                shift_en;

   // divider hookup
   logic                                div_start;
   logic signed [ACC_BITS-1:0]          div_dividend;
   logic [CNT_BITS-1:0]                 div_divisor;
   logic                                div_done;
   logic signed [SAMPLE_BITS-1:0]       div_quotient;

   // blend datapath
   logic signed [ACC_BITS-1:0]          blend_sum;
   logic [2*ACC_BITS-1:0]               blend_prod;
   logic [SAMPLE_BITS-1:0]              blend_quo;
   logic signed [SAMPLE_BITS-1:0]       blend_value;

   // classification datapath
   logic                                full;
   logic                                req_beat;
   logic                                rsp_load;
   logic signed [MAG_BITS-1:0]          x_wide, mean_wide;
   logic [MAG_BITS-1:0]                 x_mag, mean_mag;
   logic signed [LIM_BITS-1:0]          x_lim, min_lim;
   logic [CNT_BITS-1:0]                 k_sat, k_rest;
   logic signed [ACC_BITS-1:0]          x_acc, mean_acc, k_acc, k_rest_acc;
   logic signed [ACC_BITS-1:0]          oldest_acc;

   assign full     = (fill_ff == CNT_BITS'(WINDOW));
   assign req_beat = req_tvalid && req_tready;

   assign x_wide    = MAG_BITS'(sample_ff);
   assign mean_wide = MAG_BITS'(mean_ff);
   assign x_mag     = x_wide[MAG_BITS-1] ? (-x_wide) : x_wide;
   assign mean_mag  = mean_wide[MAG_BITS-1] ? (-mean_wide) : mean_wide;
   assign x_lim     = LIM_BITS'(sample_ff);
   assign min_lim   = LIM_BITS'(min_valid_ff);

   // Saturate the blend weight to the window length.
   assign k_sat      = (32'(blend_ff) > WINDOW) ? CNT_BITS'(WINDOW) : CNT_BITS'(blend_ff);
   assign k_rest     = CNT_BITS'(WINDOW) - k_sat;
   assign x_acc      = ACC_BITS'(sample_ff);
   assign mean_acc   = ACC_BITS'(mean_ff);
   assign k_acc      = ACC_BITS'(k_sat);
   assign k_rest_acc = ACC_BITS'(k_rest);
   assign oldest_acc = ACC_BITS'(cell_q[WINDOW-1]);

   // Weighted blend over WINDOW: split off the sign, multiply the magnitude by the
   // reciprocal, take the high bits and put the sign back (truncates toward zero).
   assign blend_sum   = prod_a_ff + prod_b_ff;
   assign blend_prod  = (2*ACC_BITS)'(blend_mag_ff) * (2*ACC_BITS)'(BLEND_RECIP);
   assign blend_quo   = blend_prod[BLEND_SHIFT +: SAMPLE_BITS];
   assign blend_value = blend_neg_ff ? -$signed(blend_quo) : $signed(blend_quo);

   // Window chain: a new value enters cell 0, the oldest leaves the last cell.
   assign shift_en = (state_ff == lwma_pkg::ST_STORE);

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      lwma_cell #(
         .WIDTH (SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d        ((i == 0) ? value_ff : cell_q[(i == 0) ? 0 : i-1]),
         .q        (cell_q[i])
      );
   end

   // Serial divider: running sum over fill count.
   assign div_start    = (state_ff == lwma_pkg::ST_MEAN_START);
   assign div_dividend = sum_ff;
   assign div_divisor  = fill_ff;

   lwma_div #(
      .ACC_BITS (ACC_BITS),
      .DEN_BITS (CNT_BITS),
      .Q_BITS   (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Configuration writes
   always_comb begin
      mode_in      = mode_ff;
      min_valid_in = min_valid_ff;
      blend_in     = blend_ff;
      if (csr_we) begin
         unique case (csr_index)
            lwma_pkg::CSR_MODE:         mode_in      = csr_wdata[0];
            lwma_pkg::CSR_MIN_VALID:    min_valid_in = csr_wdata[MB-1:0];
            lwma_pkg::CSR_BLEND_WEIGHT: blend_in     = csr_wdata[lwma_pkg::BLEND_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      sample_in    = sample_ff;
      value_in     = value_ff;
      class_in     = class_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      blend_neg_in = blend_neg_ff;
      blend_mag_in = blend_mag_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_class_in = rsp_class_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_load     = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         lwma_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               state_in  = lwma_pkg::ST_CLASSIFY;
            end
         end
         lwma_pkg::ST_CLASSIFY: begin
            value_in = sample_ff;
            class_in = lwma_pkg::CLASS_STORED;
            state_in = lwma_pkg::ST_STORE;
            if (mode_ff == lwma_pkg::MODE_PLAIN) begin
               // plain average: store raw
            end else if (x_lim < min_lim) begin
               // reject: leave state alone, report old mean
               class_in = lwma_pkg::CLASS_REJECTED;
               state_in = lwma_pkg::ST_FINISH;
            end else if (!full) begin
               // filling: store raw
            end else if ((x_mag + (x_mag << 1)) <= (mean_mag << 2)) begin
               // close to the mean: store raw
            end else if (x_mag < (mean_mag << 1)) begin
               class_in = lwma_pkg::CLASS_BLENDED;
               state_in = lwma_pkg::ST_BLEND_MUL;
            end else begin
               value_in = mean_ff;
               class_in = lwma_pkg::CLASS_REPLACED;
            end
         end
         lwma_pkg::ST_BLEND_MUL: begin
            prod_a_in = x_acc * k_acc;
            prod_b_in = mean_acc * k_rest_acc;
            state_in  = lwma_pkg::ST_BLEND_START;
         end
         lwma_pkg::ST_BLEND_START: begin
            // Hold the sign and magnitude of the weighted sum.
            blend_neg_in = blend_sum[ACC_BITS-1];
            blend_mag_in = blend_sum[ACC_BITS-1] ? -blend_sum : blend_sum;
            state_in     = lwma_pkg::ST_BLEND_WAIT;
         end
         lwma_pkg::ST_BLEND_WAIT: begin
            value_in = blend_value;
            state_in = lwma_pkg::ST_STORE;
         end
         lwma_pkg::ST_STORE: begin
            // Add the new value; drop the oldest once the window is full.
            sum_in = sum_ff + ACC_BITS'(value_ff) - (full ? oldest_acc : '0);
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = lwma_pkg::ST_MEAN_START;
         end
         lwma_pkg::ST_MEAN_START: begin
            state_in = lwma_pkg::ST_MEAN_WAIT;
         end
         lwma_pkg::ST_MEAN_WAIT: begin
            if (div_done) begin
               mean_in  = div_quotient;
               state_in = lwma_pkg::ST_FINISH;
            end
         end
         lwma_pkg::ST_FINISH: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_class_in = class_ff;
               rsp_full_in  = full;
               state_in     = lwma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lwma_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lwma_pkg::MODE_RESET;
         min_valid_ff <= lwma_pkg::MIN_VALID_RESET;
         blend_ff     <= lwma_pkg::BLEND_RESET;
         state_ff     <= lwma_pkg::ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         min_valid_ff <= min_valid_in;
         blend_ff     <= blend_in;
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      value_ff     <= value_in;
      class_ff     <= class_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      blend_neg_ff <= blend_neg_in;
      blend_mag_ff <= blend_mag_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_class_ff <= rsp_class_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(unsigned'(rsp_mean_ff));
   assign rsp_tuser  = {rsp_full_ff, rsp_class_ff};

   // The divider only finishes while the sequencer waits for the mean.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lwma_pkg::ST_MEAN_WAIT))
      else $error("divider finished outside a wait state");

   // An accepted beat always moves on to classification.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == lwma_pkg::ST_CLASSIFY))
      else $error("accepted beat not classified");

   // The fill count only grows, one step at a time, and never past the window.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + 1'b1) &&
                         fill_ff <= CNT_BITS'(WINDOW)))
      else $error("fill count out of step");

   // A result marked full implies the window really is full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[lwma_pkg::CLASS_BITS]) |-> full)
      else $error("full flag without a full window");

endmodule
